[hdl/jvdw_pkg.sv]
// ----------------------------------------------------------------------------
// jvdw_pkg
// Shared types and constants of the JSON value decimal writer: item structs,
// function codes, ASCII bytes, the divide-by-ten reciprocal and the
// controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package jvdw_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int MAX_DIGITS  = 5;
    localparam int CNT_W       = $clog2(MAX_DIGITS);

    // Divide by ten as a multiply by a scaled reciprocal; the estimate is
    // never high and at most one low, so one compare-and-subtract fixes it.
    localparam int DIV_SHIFT = VALUE_WIDTH + 4;
    localparam int RECIP_W   = VALUE_WIDTH + 1;
    localparam int PROD_W    = VALUE_WIDTH + RECIP_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_SHIFT) / 64'd10) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [4:0] RADIX = 5'd10;

    // Function codes; the writer state uses the same codes.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_END   = 2'd1;
    localparam logic [1:0] FUNC_NAME  = 2'd2;
    localparam logic [1:0] FUNC_VALUE = 2'd3;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    // Output byte source select.
    localparam logic [1:0] SEL_BRACE = 2'd0;
    localparam logic [1:0] SEL_SIGN  = 2'd1;
    localparam logic [1:0] SEL_DIGIT = 2'd2;
    localparam logic [1:0] SEL_COMMA = 2'd3;

    typedef struct packed {
        logic [1:0]             func;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic                   negative;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       cnt_dec;
        logic       emit;
        logic [1:0] emit_sel;
        logic       emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic comma;
        logic cnt_zero;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/json_value_decimal_writer_core.sv]
// ----------------------------------------------------------------------------
// json_value_decimal_writer_core
// Compact JSON text writer: braces, name bookkeeping and decimal values with
// optional minus sign and trailing comma, one ASCII byte per result.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   output    out        o_out_valid / i_out_ready  o_out_data (t_out_item)
//
// A value request is accepted, converted by the divide-by-ten unit one decimal
// digit per step, then written one byte at a time (sign, digits, comma). A brace
// request is accepted, then writes its brace; a name request only sets the state.
// The digit unit and the single output byte register pace the writer.
// Reset is synchronous, active low; the writer state returns to end object.
// A stalled output holds its byte; a new request is taken only in idle.
// ----------------------------------------------------------------------------
module json_value_decimal_writer_core import jvdw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    jvdw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_ready (o_in_ready)
    );

    jvdw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[hdl/jvdw_datapath.sv]
// ----------------------------------------------------------------------------
// jvdw_datapath
// Request registers, divide-by-ten digit unit, digit store, writer state and
// the output byte register.
// ----------------------------------------------------------------------------
module jvdw_datapath import jvdw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_neg;
    logic                   r_comma;
    logic [7:0]             r_brace;
    logic [1:0]             r_wstate;
    logic [CNT_W-1:0]       r_cnt;
    logic [3:0]             r_digs [0:MAX_DIGITS-1];
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [PROD_W-1:0]      prod;
    logic [VALUE_WIDTH-1:0] q_est;
    logic [VALUE_WIDTH-1:0] ten_q;
    logic [VALUE_WIDTH-1:0] rem_est;
    logic [VALUE_WIDTH-1:0] quot;
    logic [3:0]             digit;
    logic                   conv_done;
    t_out_item              n_out;

    // One decimal digit per step.
    always_comb begin
        prod    = PROD_W'(r_val) * PROD_W'(RECIP);
        q_est   = VALUE_WIDTH'(prod[PROD_W-1:DIV_SHIFT]);
        ten_q   = (q_est << 3) + (q_est << 1);
        rem_est = r_val - ten_q;
        if (rem_est[4:0] >= RADIX) begin
            quot  = q_est + VALUE_WIDTH'(1);
            digit = 4'(rem_est[4:0] - RADIX);
        end else begin
            quot  = q_est;
            digit = rem_est[3:0];
        end
        conv_done = (quot == '0) || (r_cnt == CNT_W'(MAX_DIGITS - 1));
    end

    always_comb begin
        n_out.last = i_cmd.emit_last;
        case (i_cmd.emit_sel)
            SEL_BRACE: n_out.out_char = r_brace;
            SEL_SIGN:  n_out.out_char = CHAR_MINUS;
            SEL_DIGIT: n_out.out_char = CHAR_ZERO + {4'b0, r_digs[r_cnt]};
            SEL_COMMA: n_out.out_char = CHAR_COMMA;
            default:   n_out.out_char = CHAR_COMMA;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstate    <= FUNC_END;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_wstate <= i_in_data.func;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val   <= i_in_data.magnitude;
            r_neg   <= i_in_data.negative;
            r_comma <= (r_wstate == FUNC_NAME);
            r_brace <= (i_in_data.func == FUNC_START) ? CHAR_LBRACE : CHAR_RBRACE;
            r_cnt   <= '0;
        end
        if (i_cmd.conv_step) begin
            r_digs[r_cnt] <= digit;
            r_val         <= quot;
            // hold the count on the last digit so it points at the top digit
            if (!conv_done) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.conv_done = conv_done;
    assign o_sts.neg       = r_neg;
    assign o_sts.comma     = r_comma;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/jvdw_ctrl.sv]
// ----------------------------------------------------------------------------
// jvdw_ctrl
// Sequencer: takes a request, runs the digit conversion, then steps through
// sign, digits, comma or brace as the output register frees up.
// ----------------------------------------------------------------------------
module jvdw_ctrl import jvdw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_in_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_DIGIT = 3'd3;
    localparam logic [2:0] S_COMMA = 3'd4;
    localparam logic [2:0] S_BRACE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_func)
                        FUNC_START: n_state = S_BRACE;
                        FUNC_END:   n_state = S_BRACE;
                        FUNC_NAME:  n_state = S_IDLE;
                        FUNC_VALUE: n_state = S_CONV;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = i_sts.neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_SIGN;
                    n_state        = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = SEL_DIGIT;
                    o_cmd.emit_last = i_sts.cnt_zero && !i_sts.comma;
                    if (i_sts.cnt_zero) begin
                        n_state = i_sts.comma ? S_COMMA : S_IDLE;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end
            end
            S_COMMA: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = SEL_COMMA;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_BRACE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = SEL_BRACE;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hdl/jvdw_checker.sv]
// ----------------------------------------------------------------------------
// jvdw_checker
// Port-level checks of the writer, bound to the top level.
// ----------------------------------------------------------------------------
module jvdw_checker import jvdw_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Hold a stalled output byte.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output byte changed");

    // A brace is always the only byte of its request.
    a_brace_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.out_char == CHAR_LBRACE ||
                        o_out_data.out_char == CHAR_RBRACE) |-> o_out_data.last)
        else $error("brace byte not flagged last");

    // Digits always follow a minus sign.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_char == CHAR_MINUS |-> !o_out_data.last)
        else $error("minus sign flagged last");

    // A name request produces nothing, so the input stays open.
    a_name_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.func == FUNC_NAME |=> o_in_ready)
        else $error("name request blocked the input");

endmodule

bind json_value_decimal_writer_core jvdw_checker u_jvdw_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_value_decimal_writer_core. Requests are sent
// with random idle gaps on the request side and random stalls on the byte
// side. An in-bench model of the writer state predicts the JSON bytes of each
// accepted request, and every byte taken from the block is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import jvdw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_REQUESTS = 400;
    localparam int DRAIN_EVERY     = 100;
    localparam int END_SETTLE      = 32;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DECIMAL_BASE    = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    t_out_item  expected_text[$];
    logic [1:0] writer_state_model;

    bit in_gaps_on;
    bit out_stall_on;
    int requests_sent;
    int values_sent;
    int names_sent;
    int braces_sent;
    int bytes_checked;
    int error_count;
    int cycle_count;

    json_value_decimal_writer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause(bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] rand_magnitude();
        case ($urandom_range(0, 5))
            0: return VALUE_WIDTH'($urandom_range(0, 9));
            1: return VALUE_WIDTH'($urandom_range(10, 99));
            2: return VALUE_WIDTH'($urandom_range(100, 999));
            3: return VALUE_WIDTH'($urandom_range(1000, 9999));
            4: return VALUE_WIDTH'($urandom_range(10000, 65535));
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    // Update the writer state and queue the bytes one request produces.
    function automatic void predict_json_bytes(t_in_item req);
        logic [7:0]             text[$];
        logic [7:0]             digit_chars[MAX_DIGITS];
        logic [VALUE_WIDTH-1:0] rest;
        int                     ndig;
        t_out_item              entry;
        case (req.func)
            FUNC_START: begin
                text.push_back(CHAR_LBRACE);
                writer_state_model = FUNC_START;
            end
            FUNC_END: begin
                text.push_back(CHAR_RBRACE);
                writer_state_model = FUNC_END;
            end
            FUNC_NAME: begin
                writer_state_model = FUNC_NAME;
            end
            default: begin
                rest = req.magnitude;
                ndig = 0;
                do begin
                    digit_chars[ndig] = CHAR_ZERO + 8'(rest % DECIMAL_BASE);
                    rest = VALUE_WIDTH'(rest / DECIMAL_BASE);
                    ndig++;
                end while (rest != 0 && ndig < MAX_DIGITS);
                if (req.negative) text.push_back(CHAR_MINUS);
                for (int k = ndig - 1; k >= 0; k--) text.push_back(digit_chars[k]);
                if (writer_state_model == FUNC_NAME) text.push_back(CHAR_COMMA);
                writer_state_model = FUNC_VALUE;
            end
        endcase
        foreach (text[k]) begin
            entry.out_char = text[k];
            entry.last     = (k == text.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    // Enter and leave at a falling edge; valid stays high when no pause follows,
    // so the caller must send again at once or call wait_for_text.
    task automatic send_request(input logic [1:0] func, input logic [VALUE_WIDTH-1:0] mag,
                                input logic neg);
        t_in_item req;
        int       pause;
        req.func      = func;
        req.magnitude = mag;
        req.negative  = neg;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_json_bytes(req);
        requests_sent++;
        case (func)
            FUNC_VALUE: values_sent++;
            FUNC_NAME:  names_sent++;
            default:    braces_sent++;
        endcase
        @(negedge i_clk);
        pause = pick_pause(in_gaps_on);
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_text();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_text.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_object();
        int pairs;
        pairs = $urandom_range(0, 5);
        send_request(FUNC_START, VALUE_WIDTH'($urandom), 1'($urandom));
        repeat (pairs) begin
            // Skip the name now and then so values also follow values and braces.
            if ($urandom_range(0, 4) != 0) begin
                send_request(FUNC_NAME, VALUE_WIDTH'($urandom), 1'($urandom));
            end
            send_request(FUNC_VALUE, rand_magnitude(), 1'($urandom));
        end
        send_request(FUNC_END, VALUE_WIDTH'($urandom), 1'($urandom));
    endtask

    task automatic test_values_after_reset();
        send_request(FUNC_VALUE, 16'd7, 1'b0);
        send_request(FUNC_VALUE, 16'd0, 1'b1);
    endtask

    task automatic test_braces();
        send_request(FUNC_START, 16'hFFFF, 1'b1);
        send_request(FUNC_END, 16'h0000, 1'b0);
        send_request(FUNC_END, 16'hA5A5, 1'b1);
        send_request(FUNC_START, 16'h5A5A, 1'b0);
    endtask

    task automatic test_name_then_value();
        send_request(FUNC_NAME, 16'hFFFF, 1'b1);
        send_request(FUNC_VALUE, 16'd0, 1'b0);
        send_request(FUNC_NAME, 16'd0, 1'b0);
        send_request(FUNC_NAME, 16'd0, 1'b0);
        send_request(FUNC_VALUE, 16'd65535, 1'b1);
        send_request(FUNC_VALUE, 16'd10, 1'b0);
        send_request(FUNC_START, 16'd0, 1'b0);
        send_request(FUNC_NAME, 16'd0, 1'b0);
        send_request(FUNC_VALUE, 16'd0, 1'b1);
    endtask

    task automatic test_digit_counts();
        send_request(FUNC_VALUE, 16'd9, 1'b1);
        send_request(FUNC_VALUE, 16'd99, 1'b0);
        send_request(FUNC_VALUE, 16'd100, 1'b1);
        send_request(FUNC_VALUE, 16'd9999, 1'b0);
        send_request(FUNC_VALUE, 16'd10000, 1'b0);
        send_request(FUNC_VALUE, 16'd32768, 1'b1);
        send_request(FUNC_VALUE, 16'd1, 1'b0);
        send_request(FUNC_END, 16'd0, 1'b0);
        wait_for_text();
    endtask

    task automatic test_random_documents();
        int first;
        int next_drain;
        first      = requests_sent;
        next_drain = DRAIN_EVERY;
        while (requests_sent - first < RANDOM_REQUESTS) begin
            in_gaps_on   = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) begin
                send_object();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(2'($urandom), VALUE_WIDTH'($urandom), 1'($urandom));
                end
            end
            // Hold off until the block has drained everything.
            if (requests_sent - first >= next_drain) begin
                wait_for_text();
                next_drain += DRAIN_EVERY;
            end
        end
        wait_for_text();
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            int stall_left;
            @(negedge i_clk);
            if (!out_stall_on) begin
                i_out_ready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_pause(1'b1);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_text.size() == 0) begin
                $error("unexpected byte: out_char %h last %b", o_out_data.out_char,
                       o_out_data.last);
                error_count++;
            end else begin
                t_out_item want;
                want = expected_text.pop_front();
                bytes_checked++;
                if (o_out_data.out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char,
                           o_out_data.out_char);
                    error_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_out_data.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in_data          = '0;
        writer_state_model = FUNC_END;
        in_gaps_on         = 1'b1;
        out_stall_on       = 1'b1;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_values_after_reset();
        test_braces();
        test_name_then_value();
        test_digit_counts();
        test_random_documents();

        repeat (END_SETTLE) @(negedge i_clk);
        if (expected_text.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_text.size());
            error_count++;
        end
        $display("Sent %0d requests: %0d values, %0d names, %0d braces.",
                 requests_sent, values_sent, names_sent, braces_sent);
        $display("Checked %0d output bytes under random idles on both channels.",
                 bytes_checked);
        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
